// ----- rtl/gcib_pkg.sv -----
// Shared constants, widths and the arctangent table for the bearing pipeline.
package gcib_pkg;

  // Width of the binary angle (a full turn is 2^32).
  localparam int AW = 32;
  // Width of the sine/cosine datapath (Q2.30 plus headroom).
  localparam int CW = 33;
  // Width of the products after the Q30 renormalizing shift.
  localparam int PW = 34;
  // Width of the vectoring datapath, which grows by the CORDIC gain.
  localparam int VW = 36;
  // Number of coordinate lanes in the degree-to-turn converter.
  localparam int NCONV = 4;
  // Number of angle lanes in the sine/cosine stage.
  localparam int NROT = 3;
  // Magnitude width of a coordinate.
  localparam int MW = 25;
  // Quotient width of a magnitude divided by 45.
  localparam int QW = 20;
  // Remainder width of a division by 45.
  localparam int RW = 6;
  // Reciprocal of 45 scaled by 2^31, rounded up; exact for 25-bit magnitudes.
  localparam int RECIP_SH = 31;
  localparam logic [25:0] RECIP_45 = 26'd47721859;
  localparam int DIV45 = 45;
  // Degrees in a full turn.
  localparam int DEG_TURN = 360;

  // Rotation start vector: the inverse CORDIC gain in Q30.
  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [CW-1:0] TURN_QUARTER = 33'sd1073741824;
  localparam logic signed [CW-1:0] TURN_HALF = 33'sd2147483648;
  localparam logic [AW-1:0] TURN_HALF_U = 32'h8000_0000;

  // Arctangent of 2^-i as a fraction of a full turn.
  function automatic logic [AW-1:0] gcib_atan(input int idx);
    logic [AW-1:0] a;
    case (idx)
      0: a = 32'h20000000;
      1: a = 32'h12E4051E;
      2: a = 32'h09FB385B;
      3: a = 32'h051111D4;
      4: a = 32'h028B0D43;
      5: a = 32'h0145D7E1;
      6: a = 32'h00A2F61E;
      7: a = 32'h00517C55;
      8: a = 32'h0028BE53;
      9: a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      24: a = 32'h00000029;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      28: a = 32'h00000003;
      29: a = 32'h00000001;
      30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/gcib_rot.sv -----
// Pipelined rotation CORDIC giving sine and cosine of three angles in parallel.
module gcib_rot #(
  parameter int STEPS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [gcib_pkg::AW-1:0]      ang [gcib_pkg::NROT],
  output logic                         out_vld,
  output logic signed [gcib_pkg::CW-1:0] sin_o [gcib_pkg::NROT],
  output logic signed [gcib_pkg::CW-1:0] cos_o [gcib_pkg::NROT]
);
  import gcib_pkg::*;

  logic signed [CW-1:0] x_r [STEPS+1][NROT];
  logic signed [CW-1:0] y_r [STEPS+1][NROT];
  logic signed [CW-1:0] z_r [STEPS+1][NROT];
  logic                 neg_r [STEPS+1][NROT];
  logic                 vld_r [STEPS+1];
  logic                 out_vld_r;
  logic signed [CW-1:0] sin_r [NROT];
  logic signed [CW-1:0] cos_r [NROT];

  // Fold each angle into the right half plane; remember to negate the result.
  for (genvar l = 0; l < NROT; l++) begin : g_fold
    logic signed [CW-1:0] za;
    logic signed [CW-1:0] zf_nxt;
    logic                 neg_nxt;

    assign za = signed'({ang[l][AW-1], ang[l]});

    always_comb begin
      zf_nxt = za;
      neg_nxt = 1'b0;
      if (za > TURN_QUARTER) begin
        zf_nxt = za - TURN_HALF;
        neg_nxt = 1'b1;
      end else if (za < -TURN_QUARTER) begin
        zf_nxt = za + TURN_HALF;
        neg_nxt = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[0][l] <= CORDIC_GAIN;
        y_r[0][l] <= '0;
        z_r[0][l] <= zf_nxt;
        neg_r[0][l] <= neg_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  // One micro-rotation per stage, driving the residual angle toward zero.
  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam logic signed [CW-1:0] ATAN_J = signed'({1'b0, gcib_atan(j)});

    for (genvar l = 0; l < NROT; l++) begin : g_lane
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;

      assign dx = y_r[j][l] >>> j;
      assign dy = x_r[j][l] >>> j;

      always_ff @(posedge clk) begin
        if (en) begin
          if (z_r[j][l] >= 0) begin
            x_r[j+1][l] <= x_r[j][l] - dx;
            y_r[j+1][l] <= y_r[j][l] + dy;
            z_r[j+1][l] <= z_r[j][l] - ATAN_J;
          end else begin
            x_r[j+1][l] <= x_r[j][l] + dx;
            y_r[j+1][l] <= y_r[j][l] - dy;
            z_r[j+1][l] <= z_r[j][l] + ATAN_J;
          end
          neg_r[j+1][l] <= neg_r[j][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (en) begin
        vld_r[j+1] <= vld_r[j];
      end
    end
  end

  // Undo the half-turn fold.
  for (genvar l = 0; l < NROT; l++) begin : g_out
    always_ff @(posedge clk) begin
      if (en) begin
        sin_r[l] <= neg_r[STEPS][l] ? -y_r[STEPS][l] : y_r[STEPS][l];
        cos_r[l] <= neg_r[STEPS][l] ? -x_r[STEPS][l] : x_r[STEPS][l];
      end
    end
    assign sin_o[l] = sin_r[l];
    assign cos_o[l] = cos_r[l];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[STEPS];
    end
  end

  assign out_vld = out_vld_r;

endmodule

// ----- rtl/gcib_vec.sv -----
// Pipelined vectoring CORDIC giving atan2 of a vector as a binary angle.
module gcib_vec #(
  parameter int STEPS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic signed [gcib_pkg::PW-1:0] in_y,
  input  logic signed [gcib_pkg::PW-1:0] in_x,
  output logic                          out_vld,
  output logic [gcib_pkg::AW-1:0]       out_z
);
  import gcib_pkg::*;

  logic signed [VW-1:0] x_r [STEPS+1];
  logic signed [VW-1:0] y_r [STEPS+1];
  logic [AW-1:0]        z_r [STEPS+1];
  logic                 zero_r [STEPS+1];
  logic                 vld_r [STEPS+1];
  logic signed [VW-1:0] xe;
  logic signed [VW-1:0] ye;

  assign xe = VW'(in_x);
  assign ye = VW'(in_y);

  // Move the vector into the right half plane; flag the null vector.
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (in_x == 0) && (in_y == 0);
      if (in_x < 0) begin
        x_r[0] <= -xe;
        y_r[0] <= -ye;
        z_r[0] <= TURN_HALF_U;
      end else begin
        x_r[0] <= xe;
        y_r[0] <= ye;
        z_r[0] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  // One micro-rotation per stage, driving y toward zero.
  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam logic [AW-1:0] ATAN_J = gcib_atan(j);
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;

    assign dx = y_r[j] >>> j;
    assign dy = x_r[j] >>> j;

    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[j] >= 0) begin
          x_r[j+1] <= x_r[j] + dx;
          y_r[j+1] <= y_r[j] - dy;
          z_r[j+1] <= z_r[j] + ATAN_J;
        end else begin
          x_r[j+1] <= x_r[j] - dx;
          y_r[j+1] <= y_r[j] + dy;
          z_r[j+1] <= z_r[j] - ATAN_J;
        end
        zero_r[j+1] <= zero_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (en) begin
        vld_r[j+1] <= vld_r[j];
      end
    end
  end

  // A null vector has bearing zero.
  assign out_z = zero_r[STEPS] ? '0 : z_r[STEPS];
  assign out_vld = vld_r[STEPS];

endmodule

// ----- rtl/great_circle_initial_bearing.sv -----
// Top level of the initial great-circle bearing pipeline.
// Each transaction carries a start and an end point in signed fixed-point degrees and
// yields one bearing, clockwise from north in [0,360) degrees with FRAC_BITS fractional
// bits. The pipeline takes one transaction per clock while the output is not stalled.
// Four stages turn degrees into binary angles, one forms the longitude difference, the
// sine/cosine CORDIC follows with a fold register, its micro-rotation stages and an undo
// register, three stages form the atan2 operands, then the vectoring CORDIC with a fold
// register and its micro-rotation stages, and the output register scales back to degrees.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
module great_circle_initial_bearing #(
  parameter int FRAC_BITS = 16,
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_start_lat,
  input  logic signed [24:0] in_start_lon,
  input  logic signed [23:0] in_end_lat,
  input  logic signed [24:0] in_end_lon,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [24:0]        out_bearing
);
  import gcib_pkg::*;

  localparam int STEPS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
  // Degrees to turns: v * 2^(32-F) / 360 = v * 2^K / 45.
  localparam int K = 29 - FRAC_BITS;
  localparam int OUT_SH = AW - FRAC_BITS;
  localparam longint BEAR_LIM = longint'(DEG_TURN) * (64'sd1 << FRAC_BITS);

  logic en;

  // Degree-to-turn converter, one lane per coordinate.
  logic signed [MW-1:0] in_v [NCONV];
  logic [MW-1:0]        cv_abs0_r [NCONV];
  logic                 cv_neg0_r [NCONV];
  logic [MW-1:0]        cv_abs1_r [NCONV];
  logic [QW-1:0]        cv_q1_r [NCONV];
  logic                 cv_neg1_r [NCONV];
  logic [QW-1:0]        cv_q2_r [NCONV];
  logic [RW-1:0]        cv_rem2_r [NCONV];
  logic                 cv_neg2_r [NCONV];
  logic [AW-1:0]        cv_turn_r [NCONV];
  logic                 cv_vld_r [4];
  logic [AW-1:0]        rem_tbl [2**RW];

  // Angles for the sine/cosine unit: start latitude, end latitude, longitude difference.
  logic [AW-1:0]        ang_r [NROT];
  logic                 ang_vld_r;

  logic                 rot_vld;
  logic signed [CW-1:0] rot_sin [NROT];
  logic signed [CW-1:0] rot_cos [NROT];

  // atan2 operand stages.
  logic signed [PW-1:0] ma_y_r;
  logic signed [PW-1:0] ma_b_r;
  logic signed [CW-1:0] ma_c_r;
  logic signed [CW-1:0] ma_cd_r;
  logic                 ma_vld_r;
  logic signed [PW-1:0] mb_y_r;
  logic signed [PW-1:0] mb_b_r;
  logic signed [PW-1:0] mb_d_r;
  logic                 mb_vld_r;
  logic signed [PW-1:0] mc_y_r;
  logic signed [PW-1:0] mc_x_r;
  logic                 mc_vld_r;

  logic signed [2*CW-1:0] prod_y;
  logic signed [2*CW-1:0] prod_b;
  logic signed [2*CW-1:0] prod_c;
  logic signed [2*CW-1:0] prod_d;

  logic                 vec_vld;
  logic [AW-1:0]        vec_z;
  logic [AW+8:0]        deg_prod;
  logic [AW+8:0]        deg_shift;

  logic                 out_valid_r;
  logic [24:0]          out_bearing_r;

  // The pipeline advances unless a finished result is held by the receiver.
  assign en = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign in_v[0] = MW'(in_start_lat);
  assign in_v[1] = MW'(in_start_lon);
  assign in_v[2] = MW'(in_end_lat);
  assign in_v[3] = MW'(in_end_lon);

  // Constant table: floor(r * 2^K / 45) for each remainder r.
  for (genvar g = 0; g < 2**RW; g++) begin : g_tbl
    localparam logic [AW-1:0] TBL_V =
      (g < DIV45) ? AW'((64'(g) << K) / DIV45) : '0;
    assign rem_tbl[g] = TBL_V;
  end

  for (genvar c = 0; c < NCONV; c++) begin : g_conv
    logic [MW+25:0] prod_q;
    logic [MW-1:0]  rem_w;
    logic [63:0]    mag_w;
    logic [AW-1:0]  mag32;

    assign prod_q = (MW+26)'(cv_abs0_r[c]) * (MW+26)'(RECIP_45);
    assign rem_w = cv_abs1_r[c] - MW'(cv_q1_r[c] * MW'(DIV45));
    assign mag_w = (64'(cv_q2_r[c]) << K) | 64'(rem_tbl[cv_rem2_r[c]]);
    assign mag32 = mag_w[AW-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        // Split sign and magnitude.
        cv_neg0_r[c] <= in_v[c][MW-1];
        cv_abs0_r[c] <= in_v[c][MW-1] ? MW'(-in_v[c]) : MW'(in_v[c]);
        // Quotient by 45 through the reciprocal.
        cv_abs1_r[c] <= cv_abs0_r[c];
        cv_neg1_r[c] <= cv_neg0_r[c];
        cv_q1_r[c] <= QW'(prod_q >> RECIP_SH);
        // Remainder by 45.
        cv_q2_r[c] <= cv_q1_r[c];
        cv_rem2_r[c] <= rem_w[RW-1:0];
        cv_neg2_r[c] <= cv_neg1_r[c];
        // Assemble the turn and restore the sign.
        cv_turn_r[c] <= cv_neg2_r[c] ? -mag32 : mag32;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_vld_r[0] <= 1'b0;
      cv_vld_r[1] <= 1'b0;
      cv_vld_r[2] <= 1'b0;
      cv_vld_r[3] <= 1'b0;
      ang_vld_r <= 1'b0;
    end else if (en) begin
      cv_vld_r[0] <= in_valid;
      cv_vld_r[1] <= cv_vld_r[0];
      cv_vld_r[2] <= cv_vld_r[1];
      cv_vld_r[3] <= cv_vld_r[2];
      ang_vld_r <= cv_vld_r[3];
    end
  end

  // Longitude difference wraps modulo a full turn.
  always_ff @(posedge clk) begin
    if (en) begin
      ang_r[0] <= cv_turn_r[0];
      ang_r[1] <= cv_turn_r[2];
      ang_r[2] <= cv_turn_r[3] - cv_turn_r[1];
    end
  end

  gcib_rot #(
    .STEPS(STEPS)
  ) u_rot (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (ang_vld_r),
    .ang    (ang_r),
    .out_vld(rot_vld),
    .sin_o  (rot_sin),
    .cos_o  (rot_cos)
  );

  // First products: sin dLon*cos lat2, cos lat1*sin lat2, sin lat1*cos lat2.
  assign prod_y = rot_sin[2] * rot_cos[1];
  assign prod_b = rot_cos[0] * rot_sin[1];
  assign prod_c = rot_sin[0] * rot_cos[1];
  // Second product: (sin lat1*cos lat2)*cos dLon.
  assign prod_d = ma_c_r * ma_cd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ma_y_r <= PW'(prod_y >>> 30);
      ma_b_r <= PW'(prod_b >>> 30);
      ma_c_r <= CW'(prod_c >>> 30);
      ma_cd_r <= rot_cos[2];
      mb_y_r <= ma_y_r;
      mb_b_r <= ma_b_r;
      mb_d_r <= PW'(prod_d >>> 30);
      mc_y_r <= mb_y_r;
      mc_x_r <= mb_b_r - mb_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ma_vld_r <= 1'b0;
      mb_vld_r <= 1'b0;
      mc_vld_r <= 1'b0;
    end else if (en) begin
      ma_vld_r <= rot_vld;
      mb_vld_r <= ma_vld_r;
      mc_vld_r <= mb_vld_r;
    end
  end

  gcib_vec #(
    .STEPS(STEPS)
  ) u_vec (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (mc_vld_r),
    .in_y   (mc_y_r),
    .in_x   (mc_x_r),
    .out_vld(vec_vld),
    .out_z  (vec_z)
  );

  // Turns back to degrees, rounding down.
  assign deg_prod = (AW+9)'(vec_z) * (AW+9)'(DEG_TURN);
  assign deg_shift = deg_prod >> OUT_SH;

  always_ff @(posedge clk) begin
    if (en) begin
      out_bearing_r <= deg_shift[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vec_vld;
    end
  end

  assign out_valid = out_valid_r;
  assign out_bearing = out_bearing_r;

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid directly after reset");

  // A delivered bearing lies below a full turn whenever the field can hold one.
  a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((BEAR_LIM > 64'sd33554432) || (longint'(out_bearing) < BEAR_LIM)))
    else $error("bearing beyond a full turn");

  // Sine and cosine of the longitude difference stay within unit magnitude plus 2^-20 after the fold is undone.
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    rot_vld |-> ((rot_cos[2] <= 33'sd1073742848) && (rot_cos[2] >= -33'sd1073742848) &&
                 (rot_sin[2] <= 33'sd1073742848) && (rot_sin[2] >= -33'sd1073742848)))
    else $error("sine or cosine out of unit range");

endmodule

// ----- bench/great_circle_initial_bearing_test.sv -----
// Self-checking testbench for the great-circle initial bearing pipeline.
`timescale 1ns / 100ps

module great_circle_initial_bearing_test;

  typedef struct packed {
    logic signed [23:0] start_lat;
    logic signed [24:0] start_lon;
    logic signed [23:0] end_lat;
    logic signed [24:0] end_lon;
  } point_pair_t;

  localparam int LAT_MAX = 5898240;
  localparam int LON_MAX = 11796480;
  localparam int STEPS = 24;
  localparam int LATENCY = 2 * STEPS + 12;
  localparam logic signed [63:0] GAIN_Q30 = 64'sd652032874;
  localparam logic signed [63:0] QUARTER = 64'sd1073741824;
  localparam logic signed [63:0] HALF = 64'sd2147483648;
  localparam logic signed [63:0] FULL = 64'sd4294967296;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [23:0] in_start_lat;
  logic signed [24:0] in_start_lon;
  logic signed [23:0] in_end_lat;
  logic signed [24:0] in_end_lon;
  logic out_valid;
  logic out_stall;
  logic [24:0] out_bearing;

  point_pair_t pending_pairs[$];
  logic [24:0] expected_bearings[$];
  int error_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  logic in_accepted;

  great_circle_initial_bearing dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_start_lat(in_start_lat),
    .in_start_lon(in_start_lon),
    .in_end_lat(in_end_lat),
    .in_end_lon(in_end_lon),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_bearing(out_bearing)
  );

  // Clock generation.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Arctangent of 2^-i as a fraction of a full turn.
  function automatic logic signed [63:0] atan_turn(input int idx);
    logic [31:0] tbl[32];
    tbl = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
            32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
            32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
            32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
    return {32'd0, tbl[idx]};
  endfunction

  // Degrees times 2^16 to a binary angle, truncating toward zero.
  function automatic logic [31:0] degrees_to_turn(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v * FULL) / (64'sd360 * 64'sd65536);
    return t[31:0];
  endfunction

  // Rotation CORDIC for sine and cosine in Q30.
  function automatic void rotate_angle(input logic [31:0] ang,
                                       output logic signed [63:0] s,
                                       output logic signed [63:0] c);
    logic signed [63:0] z, x, y, dx, dy;
    bit flip;
    z = ang[31] ? $signed({32'd0, ang}) - FULL : $signed({32'd0, ang});
    x = GAIN_Q30;
    y = 0;
    flip = 0;
    if (z > QUARTER) begin
      z -= HALF;
      flip = 1;
    end else if (z < -QUARTER) begin
      z += HALF;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_turn(i);
      end else begin
        x += dx;
        y -= dy;
        z += atan_turn(i);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // Vectoring CORDIC: angle of (x, y) as a binary angle.
  function automatic logic [31:0] vector_angle(input logic signed [63:0] y,
                                               input logic signed [63:0] x);
    logic [31:0] z;
    logic signed [63:0] dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += 32'(atan_turn(i));
      end else begin
        x -= dx;
        y += dy;
        z -= 32'(atan_turn(i));
      end
    end
    return z;
  endfunction

  // Predicted forward azimuth for one point pair.
  function automatic logic [24:0] predict_bearing(input point_pair_t p);
    logic [31:0] lat1, lat2, lon1, lon2, dlon, z;
    logic signed [63:0] s1, c1, s2, c2, sd, cd, y, x;
    logic [63:0] deg;
    lat1 = degrees_to_turn(64'(p.start_lat));
    lon1 = degrees_to_turn(64'(p.start_lon));
    lat2 = degrees_to_turn(64'(p.end_lat));
    lon2 = degrees_to_turn(64'(p.end_lon));
    dlon = lon2 - lon1;
    rotate_angle(lat1, s1, c1);
    rotate_angle(lat2, s2, c2);
    rotate_angle(dlon, sd, cd);
    y = (sd * c2) >>> 30;
    x = ((c1 * s2) >>> 30) - ((((s1 * c2) >>> 30) * cd) >>> 30);
    z = vector_angle(y, x);
    deg = ({32'd0, z} * 64'd360) >> 16;
    return deg[24:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic point_pair_t make_pair(input int la1, input int lo1, input int la2,
                                            input int lo2);
    point_pair_t p;
    p.start_lat = la1[23:0];
    p.start_lon = lo1[24:0];
    p.end_lat = la2[23:0];
    p.end_lon = lo2[24:0];
    return p;
  endfunction

  function automatic int rand_span(input int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  // Remember whether the offered transaction was taken at the last rising edge.
  always @(posedge clk) begin
    in_accepted <= rst_n && in_valid && !in_stall;
  end

  // Driver: offers the next pending pair at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        point_pair_t p;
        p = pending_pairs.pop_front();
        in_valid <= 1'b1;
        in_start_lat <= p.start_lat;
        in_start_lon <= p.start_lon;
        in_end_lat <= p.end_lat;
        in_end_lon <= p.end_lon;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with one long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: predict on each accepted input transaction, check each result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_bearings.push_back(predict_bearing(make_pair(int'(in_start_lat),
            int'(in_start_lon), int'(in_end_lat), int'(in_end_lon))));
      end
      if (out_valid && !out_stall) begin
        if (expected_bearings.size() == 0) begin
          report_mismatch($sformatf("unexpected bearing %0d", out_bearing));
        end else begin
          logic [24:0] want;
          want = expected_bearings.pop_front();
          if (out_bearing !== want)
            report_mismatch($sformatf("bearing %0d, expected %0d", out_bearing, want));
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int la, lo;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    in_start_lat = '0;
    in_start_lon = '0;
    in_end_lat = '0;
    in_end_lon = '0;
    error_count = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, poles, coincident and antipodal points, raw bit extremes.
    pending_pairs.push_back(make_pair(0, 0, 0, 0));
    pending_pairs.push_back(make_pair(LAT_MAX, 0, LAT_MAX, 0));
    pending_pairs.push_back(make_pair(-LAT_MAX, 0, LAT_MAX, 0));
    pending_pairs.push_back(make_pair(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX));
    pending_pairs.push_back(make_pair(0, 0, 0, LON_MAX));
    pending_pairs.push_back(make_pair(0, -LON_MAX, 0, LON_MAX));
    pending_pairs.push_back(make_pair(0, 0, 0, 90 * 65536));
    pending_pairs.push_back(make_pair(0, 0, 0, -90 * 65536));
    pending_pairs.push_back(make_pair(0, 0, 1, 0));
    pending_pairs.push_back(make_pair(0, 0, -1, 0));
    pending_pairs.push_back(make_pair(3000000, 1000, 3000000, 1000));
    pending_pairs.push_back(make_pair(-3000000, 0, 3000000, LON_MAX));
    pending_pairs.push_back(make_pair(-LAT_MAX, LON_MAX, -LAT_MAX, 0));
    pending_pairs.push_back(make_pair(24'h7FFFFF, 25'h0FFFFFF, 24'h800000, 25'h1000000));
    pending_pairs.push_back(make_pair(24'h800000, 25'h1000000, 24'h7FFFFF, 25'h0FFFFFF));
    pending_pairs.push_back(make_pair(-1, -1, -1, -1));
    pending_pairs.push_back(make_pair(0, 1, 0, -1));
    pending_pairs.push_back(make_pair(2949120, 0, 2949120, 1));

    // Random pairs: mostly in range, some nearby or coincident, some raw bit patterns.
    for (int i = 0; i < 1200; i++) begin
      int k;
      k = $urandom_range(9);
      if (k < 6) begin
        pending_pairs.push_back(make_pair(rand_span(LAT_MAX), rand_span(LON_MAX),
                                          rand_span(LAT_MAX), rand_span(LON_MAX)));
      end else if (k < 8) begin
        la = rand_span(LAT_MAX);
        lo = rand_span(LON_MAX);
        pending_pairs.push_back(make_pair(la, lo, la + rand_span(64),
                                          lo + ($urandom_range(1) ? 0 : rand_span(64))));
      end else begin
        pending_pairs.push_back(make_pair($urandom, $urandom, $urandom, $urandom));
      end
      // Three idling phases, the last one opening with a long receiver hold-off.
      if (i == 400) begin
        wait (pending_pairs.size() < 8);
        send_idle_pct = 71;
        recv_idle_pct = 38;
      end else if (i == 800) begin
        wait (pending_pairs.size() < 8);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles <= 300;
      end
      if (i == 0) begin
        send_idle_pct = 38;
        recv_idle_pct = 71;
      end
    end

    // Wait until every pair has been accepted and every bearing delivered.
    while (pending_pairs.size() != 0 || in_valid) @(posedge clk);
    while (expected_bearings.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (error_count == 0 && expected_bearings.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("TIMEOUT");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/gcib_pkg.sv
rtl/gcib_rot.sv
rtl/gcib_vec.sv
rtl/great_circle_initial_bearing.sv
bench/great_circle_initial_bearing_test.sv
